### rtl/core/rbd_pkg.sv
// Shared types, codes and sizes for the ring buffer deque.
`default_nettype none

package rbd_pkg;

  // Storage geometry.
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // Port field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the operation at an input transfer
    logic exec;  // perform the captured operation on the store
  } rbd_cmd_t;

endpackage

`default_nettype wire

### rtl/core/ring_buffer_deque_core.sv
// Top level of the ring buffer deque: controller and datapath.
`default_nettype none

// Fixed-capacity double-ended queue (16 entries of 32 bits). Start an operation
// by raising start while busy is low; cmd_i selects push front, push back, pop
// front or pop back. Each operation has an execute step against the store, whose
// read port is registered, and a step in which the result is shown. The result
// is on value_out_o, status_o and occupancy_o for exactly one cycle while done_o
// is high, and it cannot be held off, so capture it then. busy is high only
// during the execute step, so a new operation may start in the same cycle that
// the previous result is shown. A rejected push or an empty pop leaves the
// deque unchanged and returns zero data with the matching status.
module ring_buffer_deque_core
  import rbd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic [VALUE_W-1:0]   value_in_i,
  output logic                      done_o,
  output logic [VALUE_W-1:0]        value_out_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [OCC_W-1:0]          occupancy_o
);

  rbd_cmd_t dp_cmd;

  // Operation sequencing.
  rbd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (dp_cmd)
  );

  // Storage and pointer arithmetic.
  rbd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .op_i        (cmd_i),
    .value_in_i  (value_in_i),
    .value_out_o (value_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire

### rtl/core/rbd_ctrl.sv
// Controller state machine that sequences one deque operation at a time.
`default_nettype none

module rbd_ctrl
  import rbd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  output logic          done_o,
  output rbd_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // The store is in use only in the execute state.
  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;
  assign done_o = (state_q == S_RESP);

  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == S_EXEC);

  // Next state: a new transfer may start while the last result is shown.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rbd_datapath.sv
// Datapath: circular store, head and tail indices, fill count and result registers.
`default_nettype none

module rbd_datapath
  import rbd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rbd_cmd_t             cmd_i,
  input  wire logic [CMD_W-1:0]     op_i,
  input  wire logic [VALUE_W-1:0]   value_in_i,
  output logic [VALUE_W-1:0]        value_out_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [OCC_W-1:0]          occupancy_o
);

  data_t              mem [CAPACITY];
  logic [CMD_W-1:0]   op_q;
  data_t              data_q;
  idx_t               head_q, head_d;
  idx_t               tail_q, tail_d;
  cnt_t               fill_q, fill_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic               pop_ok_q, pop_ok_d;
  data_t              rd_q;
  logic               we, re;
  idx_t               waddr, raddr;
  idx_t               head_dec, head_inc, tail_dec, tail_inc;
  logic               full, empty;

  // Index wrap around the capacity.
  assign head_dec = (head_q == '0) ? idx_t'(CAPACITY - 1) : head_q - idx_t'(1);
  assign head_inc = (head_q == idx_t'(CAPACITY - 1)) ? '0 : head_q + idx_t'(1);
  assign tail_dec = (tail_q == '0) ? idx_t'(CAPACITY - 1) : tail_q - idx_t'(1);
  assign tail_inc = (tail_q == idx_t'(CAPACITY - 1)) ? '0 : tail_q + idx_t'(1);

  assign full  = (fill_q == cnt_t'(CAPACITY));
  assign empty = (fill_q == '0);

  // Operation decode and pointer update.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    status_d = STATUS_OK;
    pop_ok_d = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = tail_q;
    raddr    = head_q;
    unique case (op_q)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          we     = 1'b1;
          waddr  = head_dec;
          head_d = head_dec;
          fill_d = fill_q + cnt_t'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          we     = 1'b1;
          waddr  = tail_q;
          tail_d = tail_inc;
          fill_d = fill_q + cnt_t'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = head_q;
          pop_ok_d = 1'b1;
          head_d   = head_inc;
          fill_d   = fill_q - cnt_t'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = tail_dec;
          pop_ok_d = 1'b1;
          tail_d   = tail_dec;
          fill_d   = fill_q - cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  // Operation capture at an input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      data_q <= data_t'(value_in_i);
    end
  end

  // Store with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= data_q;
    end
    if (cmd_i.exec && re) begin
      rd_q <= mem[raddr];
    end
  end

  // Control state and result status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      status_q <= STATUS_OK;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Result fields; the popped element is sign-extended to the port width.
  assign value_out_o = pop_ok_q ? VALUE_W'($signed(rd_q)) : '0;
  assign status_o    = status_q;
  assign occupancy_o = OCC_W'(fill_q);

endmodule

`default_nettype wire

### rtl/core/rbd_checker.sv
// Port-level checker for the ring buffer deque and its bind to the top level.
`default_nettype none

module rbd_port_props
  import rbd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done_o,
  input wire logic [VALUE_W-1:0]   value_out_o,
  input wire logic [STATUS_W-1:0]  status_o,
  input wire logic [OCC_W-1:0]     occupancy_o
);

  // Every transfer yields its result strobe once the execute state has passed.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing after a transfer");

  // A result with an error status carries zero data.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |-> (value_out_o == '0))
    else $error("error result carries data");

  // A rejected push reports a full deque.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> (occupancy_o == OCC_W'(CAPACITY)))
    else $error("full status with occupancy below capacity");

  // An empty pop reports an empty deque.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_EMPTY) |-> (occupancy_o == '0))
    else $error("empty status with nonzero occupancy");

  // Occupancy only changes when a result is shown.
  a_occ_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o && !$past(done_o)) |-> $stable(occupancy_o))
    else $error("occupancy changed without a result");

endmodule

bind ring_buffer_deque_core rbd_port_props u_rbd_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .value_out_o (value_out_o),
  .status_o    (status_o),
  .occupancy_o (occupancy_o)
);

`default_nettype wire

### tb/rbd_checker.sv
// Result checker for the ring buffer deque: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module rbd_checker
  import rbd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_i,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [VALUE_W-1:0]  value_in_i,
  input  wire logic                done_i,
  input  wire logic [VALUE_W-1:0]  value_out_i,
  input  wire logic [STATUS_W-1:0] status_i,
  input  wire logic [OCC_W-1:0]    occupancy_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       full_rejects_o,
  output int                       empty_pops_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
  } deque_result_t;

  // Our own copy of the deque contents and pointers.
  logic [VALUE_W-1:0] slots [CAPACITY];
  idx_t               front_idx;
  idx_t               back_idx;
  cnt_t               fill;

  deque_result_t awaited_results [$];
  int            failures;
  int            checked;
  int            full_rejects;
  int            empty_pops;

  function automatic idx_t step_up(input idx_t idx);
    return (idx == idx_t'(CAPACITY - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic idx_t step_down(input idx_t idx);
    return (idx == '0) ? idx_t'(CAPACITY - 1) : idx - 1'b1;
  endfunction

  // Apply one operation to the shadow deque and return the result it should give.
  function automatic deque_result_t apply_op(input logic [CMD_W-1:0] op,
                                             input logic [VALUE_W-1:0] v);
    deque_result_t r;
    r.value  = '0;
    r.status = STATUS_OK;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill == cnt_t'(CAPACITY)) begin
          r.status = STATUS_FULL;
          full_rejects++;
        end else if (op == CMD_PUSH_FRONT) begin
          front_idx        = step_down(front_idx);
          slots[front_idx] = v;
          fill             = fill + 1'b1;
        end else begin
          slots[back_idx] = v;
          back_idx        = step_up(back_idx);
          fill            = fill + 1'b1;
        end
      end
      default: begin
        if (fill == '0) begin
          r.status = STATUS_EMPTY;
          empty_pops++;
        end else if (op == CMD_POP_FRONT) begin
          r.value   = slots[front_idx];
          front_idx = step_up(front_idx);
          fill      = fill - 1'b1;
        end else begin
          back_idx = step_down(back_idx);
          r.value  = slots[back_idx];
          fill     = fill - 1'b1;
        end
      end
    endcase
    r.occ = OCC_W'(fill);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: MISMATCH %s", $realtime, msg);
    end
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_result();
    deque_result_t want;
    if (awaited_results.size() == 0) begin
      note_failure($sformatf("unexpected result value=%h status=%0d occ=%0d",
                             value_out_i, status_i, occupancy_i));
    end else begin
      want = awaited_results.pop_front();
      checked++;
      if (value_out_i !== want.value || status_i !== want.status ||
          occupancy_i !== want.occ) begin
        note_failure($sformatf("expected value=%h status=%0d occ=%0d, got value=%h status=%0d occ=%0d",
                               want.value, want.status, want.occ,
                               value_out_i, status_i, occupancy_i));
      end
    end
  endtask

  // A result shown now always belongs to an earlier transfer, so check before predicting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      front_idx      = '0;
      back_idx       = '0;
      fill           = '0;
      failures       = 0;
      checked        = 0;
      full_rejects   = 0;
      empty_pops     = 0;
      errors_o       <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
      full_rejects_o <= 0;
      empty_pops_o   <= 0;
    end else begin
      if (done_i) begin
        check_result();
      end
      if (start_i && !busy_i) begin
        awaited_results.push_back(apply_op(cmd_i, value_in_i));
      end
      errors_o       <= failures;
      pending_o      <= awaited_results.size();
      checked_o      <= checked;
      full_rejects_o <= full_rejects;
      empty_pops_o   <= empty_pops;
    end
  end

endmodule

### tb/tb.sv
// Testbench top for the ring buffer deque: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import rbd_pkg::*;

  localparam int RANDOM_OPS   = 1100;
  localparam int QUIET_LIMIT  = 1000;
  localparam int BLOCK_LEN    = 40;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic [CMD_W-1:0]    cmd_i      = CMD_POP_FRONT;
  logic [VALUE_W-1:0]  value_in_i = '0;
  logic                busy;
  logic                done_o;
  logic [VALUE_W-1:0]  value_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [OCC_W-1:0]    occupancy_o;

  int errors;
  int pending;
  int checked;
  int full_rejects;
  int empty_pops;
  int ops_sent     = 0;
  int quiet_cycles = 0;

  ring_buffer_deque_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .value_in_i  (value_in_i),
    .done_o      (done_o),
    .value_out_o (value_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  rbd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd_i),
    .value_in_i     (value_in_i),
    .done_i         (done_o),
    .value_out_i    (value_out_o),
    .status_i       (status_o),
    .occupancy_i    (occupancy_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_rejects_o (full_rejects),
    .empty_pops_o   (empty_pops)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT - 1) begin
        $display("Watchdog expired after %0d idle cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one operation and hold it until the input transfer happens.
  task automatic send_op(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v);
    start      <= 1'b1;
    cmd_i      <= op;
    value_in_i <= v;
    do @(posedge clk_i); while (busy);
    ops_sent++;
  endtask

  // Drop start with junk on the payload, for a fixed gap or until all results are back.
  task automatic pause_sender(input int cycles, input bit until_drained);
    start      <= 1'b0;
    cmd_i      <= CMD_W'($urandom);
    value_in_i <= $urandom;
    if (until_drained) begin
      do @(posedge clk_i); while (pending != 0);
    end else begin
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Field extremes now and then, otherwise uniform.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_after_op(input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      pause_sender(gap, 1'b0);
    end
  endtask

  initial begin
    int bias;
    int roll;
    bit no_gaps;
    logic [CMD_W-1:0] op;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pops, fill to capacity with extreme values, full pushes, pops at
    // both ends.
    send_op(CMD_POP_FRONT, 32'h1234_5678);
    idle_after_op(1'b0);
    send_op(CMD_POP_BACK, 32'hFFFF_FFFF);
    idle_after_op(1'b0);
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0: send_op(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        1: send_op(CMD_PUSH_BACK, 32'h8000_0000);
        2: send_op(CMD_PUSH_FRONT, 32'h0000_0000);
        3: send_op(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        default: send_op((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
      endcase
      idle_after_op(1'b0);
    end
    send_op(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    idle_after_op(1'b0);
    send_op(CMD_PUSH_BACK, 32'h0BAD_F00D);
    idle_after_op(1'b0);
    send_op(CMD_POP_FRONT, '0);
    idle_after_op(1'b0);
    send_op(CMD_POP_BACK, '0);
    idle_after_op(1'b0);
    send_op(CMD_POP_FRONT, '0);
    idle_after_op(1'b0);
    send_op(CMD_POP_BACK, '0);

    // Let every outstanding result come back before the random part.
    pause_sender(0, 1'b1);

    // Random: blocks that lean toward pushing, popping or neither, so the deque
    // swings between empty and full; some blocks run with no gaps at all.
    bias    = 0;
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        bias    = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (bias)
        0:       op = (roll < 80) ? ($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT)
                                  : ($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT);
        1:       op = (roll < 80) ? ($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT)
                                  : ($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
        default: op = CMD_W'($urandom);
      endcase
      send_op(op, pick_value());
      if ($urandom_range(0, 99) == 0) begin
        pause_sender(0, 1'b1);
      end else begin
        idle_after_op(no_gaps);
      end
    end

    // Wait for the last results, then idle on for anything stray.
    pause_sender(0, 1'b1);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d operations, checked %0d results", ops_sent, checked);
    $display("Rejected pushes on full: %0d, pops on empty: %0d, mismatches: %0d",
             full_rejects, empty_pops, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
